// ----- hw/rtl/wfme_pkg.sv -----
package wfme_pkg;

    // Largest maze side and the flat store that it needs
    localparam int MAX_SIDE = 64;
    localparam int CELLS    = MAX_SIDE * MAX_SIDE;
    localparam int IDX_W    = $clog2(CELLS);
    localparam int CNT_W    = IDX_W + 1;

    // Fixed field widths
    localparam int POS_W  = 7;
    localparam int TIME_W = 16;

    // Configuration register indexes
    localparam logic [1:0] REG_GRID_SIDE = 2'd0;
    localparam logic [1:0] REG_START_ROW = 2'd1;
    localparam logic [1:0] REG_START_COL = 2'd2;

    // Headings
    localparam logic [1:0] HEAD_E = 2'd0;
    localparam logic [1:0] HEAD_N = 2'd1;
    localparam logic [1:0] HEAD_W = 2'd2;
    localparam logic [1:0] HEAD_S = 2'd3;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic init;
        logic addr;
        logic read;
        logic eval;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic last;
        logic finish;
    } t_sts;

    function automatic logic [POS_W-1:0] row_next(input logic [POS_W-1:0] r,
                                                  input logic [1:0] h);
        logic [POS_W-1:0] res;
        case (h)
            HEAD_N:  res = r - POS_W'(1);
            HEAD_S:  res = r + POS_W'(1);
            default: res = r;
        endcase
        return res;
    endfunction

    function automatic logic [POS_W-1:0] col_next(input logic [POS_W-1:0] c,
                                                  input logic [1:0] h);
        logic [POS_W-1:0] res;
        case (h)
            HEAD_E:  res = c + POS_W'(1);
            HEAD_W:  res = c - POS_W'(1);
            default: res = c;
        endcase
        return res;
    endfunction

    function automatic logic on_grid(input logic [POS_W-1:0] r,
                                     input logic [POS_W-1:0] c,
                                     input logic [POS_W-1:0] side);
        return (r != '0) && (r <= side) && (c != '0) && (c <= side);
    endfunction

    // Flat index offset of one step in heading h (two's complement)
    function automatic logic [CNT_W-1:0] idx_off(input logic [1:0] h,
                                                 input logic [POS_W-1:0] side);
        logic [CNT_W-1:0] res;
        case (h)
            HEAD_E:  res = CNT_W'(1);
            HEAD_N:  res = -CNT_W'(side);
            HEAD_W:  res = '1;
            HEAD_S:  res = CNT_W'(side);
            default: res = '0;
        endcase
        return res;
    endfunction

    function automatic logic [POS_W-1:0] clamp_side(input logic [POS_W-1:0] s);
        logic [POS_W-1:0] res;
        res = s;
        if (s == '0) res = POS_W'(1);
        if (s > POS_W'(MAX_SIDE)) res = POS_W'(MAX_SIDE);
        return res;
    endfunction

    function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W-1:0] v,
                                                   input logic [POS_W-1:0] side);
        logic [POS_W-1:0] res;
        res = v;
        if (v == '0) res = POS_W'(1);
        if (v > side) res = side;
        return res;
    endfunction

endpackage

// ----- hw/rtl/wfme_ctrl.sv -----
module wfme_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  wfme_pkg::t_sts i_sts,
    output wfme_pkg::t_cmd o_cmd
);
    import wfme_pkg::*;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INIT,
        ST_ADDR,
        ST_READ,
        ST_EVAL
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_accept;

    // Hold the map input while walking, or when the final cell would meet a full output
    assign o_in_stall  = (r_state != ST_LOAD) || (r_out_valid && i_sts.last);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd      = '0;
        o_cmd.load = w_accept;
        o_cmd.init = (r_state == ST_INIT);
        o_cmd.addr = (r_state == ST_ADDR);
        o_cmd.read = (r_state == ST_READ);
        o_cmd.eval = (r_state == ST_EVAL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            case (r_state)
                ST_LOAD: begin
                    if (w_accept && i_sts.last) r_state <= ST_INIT;
                end
                ST_INIT: r_state <= ST_ADDR;
                ST_ADDR: r_state <= ST_READ;
                ST_READ: r_state <= ST_EVAL;
                ST_EVAL: begin
                    if (i_sts.finish) begin
                        r_state     <= ST_LOAD;
                        r_out_valid <= 1'b1;
                    end else begin
                        r_state <= ST_ADDR;
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

endmodule

// ----- hw/rtl/wfme_dp.sv -----
module wfme_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [wfme_pkg::POS_W-1:0] i_cfg_wdata,
    input  logic                      i_is_wall,
    input  wfme_pkg::t_cmd            i_cmd,
    output wfme_pkg::t_sts            o_sts,
    output logic                      o_escaped,
    output logic [wfme_pkg::TIME_W-1:0] o_time_taken
);
    import wfme_pkg::*;

    // Configuration
    logic [POS_W-1:0] r_grid_side, r_start_row, r_start_col;

    // Stores
    logic             wall_mem [CELLS];
    logic [3:0]       vis_mem  [CELLS];

    // Loading
    logic [CNT_W-1:0] r_loaded;
    logic [POS_W-1:0] w_eff_side;
    logic [CNT_W-1:0] w_total;
    logic [CNT_W-1:0] w_loaded_inc;

    // Walker
    logic [POS_W-1:0]  r_side, r_row, r_col;
    logic [1:0]        r_head;
    logic [TIME_W-1:0] r_count;
    logic [IDX_W-1:0]  r_idx;

    // Look-ahead stage
    logic [POS_W-1:0] r_nr, r_nc, r_rr, r_rc;
    logic             r_in_a, r_in_r;
    logic [IDX_W-1:0] r_a_idx, r_r_idx;

    // Read data
    logic [3:0] r_vis_q;
    logic       r_wa_q, r_wr_q;

    // Results
    logic              r_escaped;
    logic [TIME_W-1:0] r_time;

    // Combinational helpers
    logic [POS_W-1:0]  w_srow, w_scol;
    logic [CNT_W-1:0]  w_start_idx;
    logic [1:0]        w_rh;
    logic [POS_W-1:0]  w_nr, w_nc, w_rr, w_rc;
    logic [CNT_W-1:0]  w_a_idx, w_r_idx;
    logic              w_loop;
    logic              w_finish;
    logic              w_esc;
    logic [TIME_W-1:0] w_time;
    logic [POS_W-1:0]  n_row, n_col;
    logic [1:0]        n_head;
    logic [TIME_W-1:0] n_count;
    logic [IDX_W-1:0]  n_idx;
    logic [3:0]        w_vis_wdata;
    logic [IDX_W-1:0]  w_vis_waddr;
    logic              w_vis_we;

    assign w_eff_side   = clamp_side(r_grid_side);
    assign w_total      = CNT_W'(w_eff_side * w_eff_side);
    assign w_loaded_inc = r_loaded + CNT_W'(1);
    assign o_sts.last   = (w_loaded_inc >= w_total);
    assign o_sts.finish = w_finish;

    assign w_srow      = clamp_pos(r_start_row, w_eff_side);
    assign w_scol      = clamp_pos(r_start_col, w_eff_side);
    assign w_start_idx = CNT_W'((w_srow - POS_W'(1)) * w_eff_side)
                         + CNT_W'(w_scol - POS_W'(1));

    assign w_rh    = r_head - 2'd1;
    assign w_nr    = row_next(r_row, r_head);
    assign w_nc    = col_next(r_col, r_head);
    assign w_rr    = row_next(w_nr, w_rh);
    assign w_rc    = col_next(w_nc, w_rh);
    assign w_a_idx = CNT_W'(r_idx) + idx_off(r_head, r_side);
    assign w_r_idx = w_a_idx + idx_off(w_rh, r_side);

    // One step of the walk from the fetched neighbourhood
    always_comb begin
        w_loop   = r_vis_q[r_head];
        w_finish = 1'b0;
        w_esc    = 1'b0;
        w_time   = '0;
        n_row    = r_row;
        n_col    = r_col;
        n_head   = r_head;
        n_count  = r_count;
        n_idx    = r_idx;
        if (w_loop) begin
            w_finish = 1'b1;
        end else if (!r_in_a) begin
            w_finish = 1'b1;
            w_esc    = 1'b1;
            w_time   = r_count + TIME_W'(1);
        end else if (r_wa_q) begin
            n_head = r_head + 2'd1;
        end else begin
            n_row   = r_nr;
            n_col   = r_nc;
            n_idx   = r_a_idx;
            n_count = r_count + TIME_W'(1);
            if (!(r_in_r && r_wr_q)) begin
                n_head  = r_head - 2'd1;
                n_count = r_count + TIME_W'(2);
                if (!r_in_r) begin
                    w_finish = 1'b1;
                    w_esc    = 1'b1;
                    w_time   = r_count + TIME_W'(2);
                end else begin
                    n_row = r_rr;
                    n_col = r_rc;
                    n_idx = r_r_idx;
                end
            end
        end
    end

    // Loading clears the visited entry of each cell as it arrives
    always_comb begin
        w_vis_we    = 1'b0;
        w_vis_waddr = r_idx;
        w_vis_wdata = r_vis_q | (4'b0001 << r_head);
        if (i_cmd.load) begin
            w_vis_we    = 1'b1;
            w_vis_waddr = r_loaded[IDX_W-1:0];
            w_vis_wdata = '0;
        end else if (i_cmd.eval && !w_loop) begin
            w_vis_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) wall_mem[r_loaded[IDX_W-1:0]] <= i_is_wall;
        if (i_cmd.read) begin
            r_wa_q <= wall_mem[r_a_idx];
            r_wr_q <= wall_mem[r_r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_vis_we) vis_mem[w_vis_waddr] <= w_vis_wdata;
        if (i_cmd.read) r_vis_q <= vis_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_side <= POS_W'(1);
            r_start_row <= POS_W'(1);
            r_start_col <= POS_W'(1);
            r_loaded    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_GRID_SIDE: r_grid_side <= i_cfg_wdata;
                    REG_START_ROW: r_start_row <= i_cfg_wdata;
                    REG_START_COL: r_start_col <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_cmd.load) r_loaded <= o_sts.last ? '0 : w_loaded_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_side  <= w_eff_side;
            r_row   <= w_srow;
            r_col   <= w_scol;
            r_head  <= HEAD_E;
            r_count <= '0;
            r_idx   <= w_start_idx[IDX_W-1:0];
        end else if (i_cmd.eval) begin
            r_row   <= n_row;
            r_col   <= n_col;
            r_head  <= n_head;
            r_count <= n_count;
            r_idx   <= n_idx;
        end
        if (i_cmd.addr) begin
            r_nr    <= w_nr;
            r_nc    <= w_nc;
            r_rr    <= w_rr;
            r_rc    <= w_rc;
            r_in_a  <= on_grid(w_nr, w_nc, r_side);
            r_in_r  <= on_grid(w_rr, w_rc, r_side);
            r_a_idx <= w_a_idx[IDX_W-1:0];
            r_r_idx <= w_r_idx[IDX_W-1:0];
        end
        if (i_cmd.eval && w_finish) begin
            r_escaped <= w_esc;
            r_time    <= w_time;
        end
    end

    assign o_escaped    = r_escaped;
    assign o_time_taken = r_time;

endmodule

// ----- hw/rtl/wall_following_maze_escape.sv -----
// Map cells load one request per cycle when not stalled and return nothing. The request
// that completes a side*side map starts a walk: one set-up step, then address, read and
// evaluate for each of N iterations (at most 4*side*side + 1). The result is offered
// after the last evaluate step and holds off the next map's last cell.
// Synchronous active-low reset clears control, fill count and configuration (side and
// start to 1); stores are not cleared, visited entries are zeroed as cells load.
module wall_following_maze_escape (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration write port
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [wfme_pkg::POS_W-1:0]  i_cfg_wdata,
    // Map cell requests
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_is_wall,
    // Walk results
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_escaped,
    output logic [wfme_pkg::TIME_W-1:0] o_time_taken
);
    import wfme_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer: loading, then set-up, then address, read and evaluate steps of the walk
    wfme_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Wall map, visited store, walker registers and result register
    wfme_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_is_wall    (i_is_wall),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_escaped    (o_escaped),
        .o_time_taken (o_time_taken)
    );

    // A loop report carries no move count
    a_loop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_escaped |-> o_time_taken == '0)
        else $error("loop result with non-zero move count");

    // An escape always costs at least one move
    a_esc_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_escaped |-> o_time_taken != '0)
        else $error("escape with zero move count");

    // Map requests are held off for the whole walk
    a_walk_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.init || w_cmd.addr || w_cmd.read || w_cmd.eval |-> o_in_stall)
        else $error("map request taken during walk");

    // A result only appears straight after an evaluate step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.eval))
        else $error("result raised outside an evaluate step");

endmodule

// ----- dv/tb_wall_following_maze_escape.sv -----
`timescale 1ns / 100ps

module tb_wall_following_maze_escape;

    import wfme_pkg::*;

    // Run length and pacing
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 16;      // quiet cycles before a register write
    localparam int HOLD_CYCLES   = 400;     // long receiver hold-off
    localparam int ITEM_TARGET   = 1150;
    localparam int MAP_TARGET    = 40;
    localparam int IDLE_PCT      = 22;
    localparam int BIG_SIDE      = 16;      // largest maze that is loaded in full
    localparam int OVERSIZE_CUT  = 30;      // cells loaded under an oversized side

    // Row and column step per heading, indexed by HEAD_E .. HEAD_S
    localparam int ROW_STEP [4] = '{0, -1, 0, 1};
    localparam int COL_STEP [4] = '{1, 0, -1, 0};

    typedef struct packed {
        logic              escaped;
        logic [TIME_W-1:0] moves;
    } walk_res_t;

    // One directed maze: registers, cells (bit k is request k), an optional
    // side change after cut_at cells, and a hand-worked result where obvious
    typedef struct {
        logic [POS_W-1:0] side;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        int               cells;
        logic [15:0]      map;
        int               cut_at;
        logic [POS_W-1:0] cut_side;
        bit               typed;
        walk_res_t        want;
    } maze_row_t;

    // Ports of the block; the inputs are all known from time zero
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic [1:0]          i_cfg_idx   = REG_GRID_SIDE;
    logic [POS_W-1:0]    i_cfg_wdata = '0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    logic                i_is_wall   = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic                o_escaped;
    logic [TIME_W-1:0]   o_time_taken;

    // Our own copy of the block's registers and stores
    logic [POS_W-1:0]    side_reg = POS_W'(1);
    logic [POS_W-1:0]    row_reg  = POS_W'(1);
    logic [POS_W-1:0]    col_reg  = POS_W'(1);
    bit                  maze_walls [CELLS];
    logic [3:0]          seen_dirs  [CELLS];
    int                  cells_in = 0;

    walk_res_t           escape_q [$];      // walk results still to come
    int                  mismatch_cnt = 0;
    int                  cycle_cnt    = 0;
    int                  cells_sent   = 0;
    int                  idle_pct     = IDLE_PCT;
    int                  stall_pct    = IDLE_PCT;
    int                  hold_ask     = 0;  // bumped by the sender to start a hold-off
    int                  hold_done    = 0;
    int                  hold_left    = 0;

    // Directed mazes, small enough to work out by hand
    maze_row_t maze_rows [7] = '{
        // reset registers, single open cell: straight out east
        '{7'd1,   7'd1,   7'd1, 1, 16'h0000, 0, 7'd0, 1'b1, '{1'b1, 16'd1}},
        // side of zero treated as one, the cell itself a wall
        '{7'd0,   7'd1,   7'd1, 1, 16'h0001, 0, 7'd0, 1'b1, '{1'b1, 16'd1}},
        // start of zero clamped to (1,1), wall ahead: turn north and leave
        '{7'd2,   7'd0,   7'd0, 4, 16'h000F, 0, 7'd0, 1'b1, '{1'b1, 16'd1}},
        // boxed in on all four sides: loop, no moves reported
        '{7'd3,   7'd2,   7'd2, 9, 16'h00AA, 0, 7'd0, 1'b1, '{1'b0, 16'd0}},
        // start far beyond the grid clamped to the only cell
        '{7'd1, 7'd127,   7'd0, 1, 16'h0000, 0, 7'd0, 1'b1, '{1'b1, 16'd1}},
        // step forward, then right turn straight off the grid
        '{7'd2,   7'd2,   7'd1, 4, 16'h0000, 0, 7'd0, 1'b0, '{1'b0, 16'd0}},
        // side shrinks from three to two while loading
        '{7'd3,   7'd1,   7'd1, 6, 16'h0008, 5, 7'd2, 1'b0, '{1'b0, 16'd0}}
    };

    wall_following_maze_escape dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_is_wall    (i_is_wall),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_escaped    (o_escaped),
        .o_time_taken (o_time_taken)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit in_maze(input int r, input int c, input int s);
        return (r >= 1) && (r <= s) && (c >= 1) && (c <= s);
    endfunction

    // Load one cell; when it completes the map, walk the right-hand wall
    // follower and return its result
    function automatic void predict_escape(input bit wall, output bit done,
                                           output walk_res_t res);
        int         side;
        int         total;
        int         r;
        int         c;
        int         nr;
        int         nc;
        int         rr;
        int         rc;
        int         idx;
        int         moves;
        logic [1:0] hd;
        logic [1:0] rh;
        bit         fin;
        side = (side_reg == '0) ? 1 : ((side_reg > MAX_SIDE) ? MAX_SIDE : int'(side_reg));
        total = side * side;
        done = 1'b0;
        res.escaped = 1'b0;
        res.moves = '0;
        if (cells_in < CELLS)
            maze_walls[cells_in] = wall;
        cells_in++;
        if (cells_in < total)
            return;
        done = 1'b1;
        cells_in = 0;
        foreach (seen_dirs[i])
            seen_dirs[i] = '0;
        // clamp the start into the grid
        r = (row_reg == '0) ? 1 : ((row_reg > side) ? side : int'(row_reg));
        c = (col_reg == '0) ? 1 : ((col_reg > side) ? side : int'(col_reg));
        hd = HEAD_E;
        moves = 0;
        fin = 1'b0;
        while (!fin) begin
            idx = (r - 1) * side + (c - 1);
            if (seen_dirs[idx][hd]) begin
                // same cell and heading again: a loop
                fin = 1'b1;
            end else begin
                seen_dirs[idx][hd] = 1'b1;
                nr = r + ROW_STEP[hd];
                nc = c + COL_STEP[hd];
                if (!in_maze(nr, nc, side)) begin
                    moves++;
                    res.escaped = 1'b1;
                    fin = 1'b1;
                end else if (maze_walls[(nr - 1) * side + (nc - 1)]) begin
                    hd = hd + 2'd1;             // wall ahead: turn counterclockwise
                end else begin
                    rh = hd - 2'd1;
                    rr = nr + ROW_STEP[rh];
                    rc = nc + COL_STEP[rh];
                    r = nr;
                    c = nc;
                    moves++;
                    // right side open or off the grid: turn right and step again
                    if (!(in_maze(rr, rc, side) && maze_walls[(rr - 1) * side + (rc - 1)])) begin
                        hd = rh;
                        moves++;
                        if (!in_maze(rr, rc, side)) begin
                            res.escaped = 1'b1;
                            fin = 1'b1;
                        end else begin
                            r = rr;
                            c = rc;
                        end
                    end
                end
            end
        end
        if (res.escaped)
            res.moves = moves[TIME_W-1:0];
    endfunction

    // Offer one cell request, idling at random first, and hold it until taken
    task automatic send_cell(input bit wall, input bit typed, input walk_res_t typed_res,
                             output bit done);
        walk_res_t res;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_is_wall  <= wall;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0)
            @(posedge i_clk);
        cells_sent++;
        predict_escape(wall, done, res);
        if (done)
            escape_q.push_back(typed ? typed_res : res);
    endtask

    // Drop valid, drain every outstanding result, then give the block time to go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (escape_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [POS_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            REG_GRID_SIDE: side_reg = val;
            REG_START_ROW: row_reg  = val;
            REG_START_COL: col_reg  = val;
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Receiver: random stalls, or a long hold-off when the sender asks for one
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (hold_ask != hold_done) begin
                hold_done = hold_ask;
                hold_left = HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Compare each accepted result against the oldest expectation
    always @(posedge i_clk) begin : check_results
        walk_res_t want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (escape_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result: escaped %0b time_taken %0d",
                             o_escaped, o_time_taken);
            end else begin
                want = escape_q.pop_front();
                if (o_escaped !== want.escaped || o_time_taken !== want.moves) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("result mismatch: escaped exp %0b got %0b, time_taken exp %0d got %0d",
                                 want.escaped, o_escaped, want.moves, o_time_taken);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        bit               done;
        int               map_no;
        int               eff;
        int               total;
        int               dens;
        int               cut_at;
        int               k;
        logic [POS_W-1:0] side_v;
        logic [POS_W-1:0] row_v;
        logic [POS_W-1:0] col_v;
        walk_res_t        none;
        none = '0;

        // hold reset once, then release it
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        settle();

        // Directed mazes
        foreach (maze_rows[i]) begin
            settle();
            write_reg(REG_GRID_SIDE, maze_rows[i].side);
            write_reg(REG_START_ROW, maze_rows[i].row);
            write_reg(REG_START_COL, maze_rows[i].col);
            for (k = 0; k < maze_rows[i].cells; k++) begin
                if (maze_rows[i].cut_at != 0 && k == maze_rows[i].cut_at) begin
                    settle();
                    write_reg(REG_GRID_SIDE, maze_rows[i].cut_side);
                end
                send_cell(maze_rows[i].map[k], maze_rows[i].typed, maze_rows[i].want, done);
            end
        end

        // Pressure: one-cell mazes while the receiver holds off, so the
        // block backs up and stalls its requests
        settle();
        write_reg(REG_GRID_SIDE, POS_W'(1));
        hold_ask++;
        repeat (12) send_cell($urandom_range(1), 1'b0, none, done);

        // Random mazes: mostly small, one larger, an oversized side cut down
        // part way through loading, and some other side changes while loading
        map_no = 0;
        while (cells_sent < ITEM_TARGET || map_no < MAP_TARGET) begin
            settle();
            // no idling on either side for a stretch of mazes
            idle_pct  = (map_no >= 14 && map_no < 22) ? 0 : IDLE_PCT;
            stall_pct = idle_pct;
            if (map_no == 6) begin
                side_v = POS_W'(127);           // saturates to the largest side
                row_v  = POS_W'(127);
                col_v  = '0;
                dens   = 15;
            end else if (map_no == 24) begin
                side_v = POS_W'(BIG_SIDE);
                row_v  = POS_W'($urandom_range(1, BIG_SIDE));
                col_v  = POS_W'($urandom_range(1, BIG_SIDE));
                dens   = 30;
            end else begin
                k = $urandom_range(99);
                if (k < 4)
                    side_v = '0;
                else if (k < 10)
                    side_v = POS_W'(1);
                else
                    side_v = POS_W'($urandom_range(2, 7));
                eff = (side_v == '0) ? 1 : int'(side_v);
                if ($urandom_range(99) < 85) begin
                    row_v = POS_W'($urandom_range(1, eff));
                    col_v = POS_W'($urandom_range(1, eff));
                end else begin
                    row_v = POS_W'($urandom_range(0, 127));
                    col_v = POS_W'($urandom_range(0, 127));
                end
                dens = $urandom_range(0, 60);
            end
            write_reg(REG_GRID_SIDE, side_v);
            write_reg(REG_START_ROW, row_v);
            write_reg(REG_START_COL, col_v);

            eff = (side_v == '0) ? 1 : ((side_v > MAX_SIDE) ? MAX_SIDE : int'(side_v));
            total = eff * eff;
            cut_at = 0;
            if (total > 1 && total <= 64 && $urandom_range(99) < 12)
                cut_at = $urandom_range(1, total - 1);
            // the saturated side must not complete early; shrink it after a few cells
            if (map_no == 6)
                cut_at = OVERSIZE_CUT;

            // feed cells until the predictor sees the map complete
            k = 0;
            done = 1'b0;
            while (!done) begin
                if (cut_at != 0 && k == cut_at) begin
                    settle();
                    write_reg(REG_GRID_SIDE, POS_W'($urandom_range(1, 7)));
                end
                send_cell($urandom_range(99) < dens, 1'b0, none, done);
                k++;
            end
            map_no++;
        end

        // drain and let the block go quiet before the verdict
        settle();
        if (mismatch_cnt == 0 && escape_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
